>>> rtl/mtd_pkg.sv
package mtd_pkg;

    // Default counter width for tone timing.
    localparam int TICK_BITS_DEF = 16;

    // Widths of the configuration registers.
    localparam int THR_W   = 12;
    localparam int LIMIT_W = 16;

    // Register reset values.
    localparam logic [THR_W-1:0]   THRESHOLD_RST  = 12'd500;
    localparam logic [LIMIT_W-1:0] DOT_LIMIT_RST  = 16'd200;
    localparam logic [LIMIT_W-1:0] DASH_LIMIT_RST = 16'd600;
    localparam logic [LIMIT_W-1:0] LETTER_END_RST = 16'd800;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_THRESHOLD  = 2'd0;
    localparam logic [1:0] REG_DOT_LIMIT  = 2'd1;
    localparam logic [1:0] REG_DASH_LIMIT = 2'd2;
    localparam logic [1:0] REG_LETTER_END = 2'd3;

    // Result kinds.
    localparam logic [2:0] KIND_DOT  = 3'd0;
    localparam logic [2:0] KIND_DASH = 3'd1;
    localparam logic [2:0] KIND_SEP  = 3'd2;
    localparam logic [2:0] KIND_CHAR = 3'd3;
    localparam logic [2:0] KIND_WORD = 3'd4;
    localparam logic [2:0] KIND_END  = 3'd5;

    // Input modes.
    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    // Character codes.
    localparam logic [6:0] CH_DOT     = 7'h2E;
    localparam logic [6:0] CH_DASH    = 7'h2D;
    localparam logic [6:0] CH_SPACE   = 7'h20;
    localparam logic [6:0] CH_UNKNOWN = 7'h3F;
    localparam logic [6:0] CH_NONE    = 7'h00;

    // Largest symbol count of a letter, and the count that marks an overlong letter.
    localparam logic [2:0] COUNT_MAX  = 3'd5;
    localparam logic [2:0] COUNT_OVER = 3'd6;

    // Result queue geometry.
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = OUT_PTR_W + 1;

    typedef struct packed {
        logic        mode;
        logic [11:0] sample;
    } in_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [6:0] char_code;
        logic       last;
    } out_t;

    // Results produced by one item, pushed into the queue together.
    typedef struct packed {
        logic [1:0] n;
        out_t       first;
        out_t       second;
    } push_t;

    // Letter lookup: bit i of pattern is symbol i, set for a dash.
    function automatic logic [6:0] decode_letter(input logic [2:0] count,
                                                 input logic [4:0] pattern);
        logic [6:0] ch;
        case ({count, pattern})
            {3'd2, 5'b00010}: ch = 7'h41; // A
            {3'd4, 5'b00001}: ch = 7'h42; // B
            {3'd4, 5'b00101}: ch = 7'h43; // C
            {3'd3, 5'b00001}: ch = 7'h44; // D
            {3'd1, 5'b00000}: ch = 7'h45; // E
            {3'd4, 5'b00100}: ch = 7'h46; // F
            {3'd3, 5'b00011}: ch = 7'h47; // G
            {3'd4, 5'b00000}: ch = 7'h48; // H
            {3'd2, 5'b00000}: ch = 7'h49; // I
            {3'd4, 5'b01110}: ch = 7'h4A; // J
            {3'd3, 5'b00101}: ch = 7'h4B; // K
            {3'd4, 5'b00010}: ch = 7'h4C; // L
            {3'd2, 5'b00011}: ch = 7'h4D; // M
            {3'd2, 5'b00001}: ch = 7'h4E; // N
            {3'd3, 5'b00111}: ch = 7'h4F; // O
            {3'd4, 5'b00110}: ch = 7'h50; // P
            {3'd4, 5'b01011}: ch = 7'h51; // Q
            {3'd3, 5'b00010}: ch = 7'h52; // R
            {3'd3, 5'b00000}: ch = 7'h53; // S
            {3'd1, 5'b00001}: ch = 7'h54; // T
            {3'd3, 5'b00100}: ch = 7'h55; // U
            {3'd4, 5'b01000}: ch = 7'h56; // V
            {3'd3, 5'b00110}: ch = 7'h57; // W
            {3'd4, 5'b01001}: ch = 7'h58; // X
            {3'd4, 5'b01101}: ch = 7'h59; // Y
            {3'd4, 5'b00011}: ch = 7'h5A; // Z
            {3'd5, 5'b11110}: ch = 7'h31; // 1
            {3'd5, 5'b11100}: ch = 7'h32; // 2
            {3'd5, 5'b11000}: ch = 7'h33; // 3
            {3'd5, 5'b10000}: ch = 7'h34; // 4
            {3'd5, 5'b00000}: ch = 7'h35; // 5
            {3'd5, 5'b00001}: ch = 7'h36; // 6
            {3'd5, 5'b00011}: ch = 7'h37; // 7
            {3'd5, 5'b00111}: ch = 7'h38; // 8
            {3'd5, 5'b01111}: ch = 7'h39; // 9
            {3'd5, 5'b11111}: ch = 7'h30; // 0
            default:          ch = CH_UNKNOWN;
        endcase
        return ch;
    endfunction

endpackage

>>> rtl/morse_tone_decoder.sv
// Results: the results of an item are written into the result queue at the edge that
// accepts the item, and m_valid follows from the registered queue fill level.
// Throughput: one item per cycle while items cause at most one result and m_ready is high;
// an item with two results is given out one result at a time by the single result port.
// s_ready is high while the four-entry queue has room for two results.
// Reset (aresetn low, synchronous): tone and letter state cleared, registers at defaults.
module morse_tone_decoder #(
    parameter int TICK_BITS = mtd_pkg::TICK_BITS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  mtd_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output mtd_pkg::out_t  m_data,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    localparam int CMP_W = (TICK_BITS > mtd_pkg::LIMIT_W) ? TICK_BITS : mtd_pkg::LIMIT_W;

    logic [mtd_pkg::THR_W-1:0]   threshold_reg;
    logic [mtd_pkg::LIMIT_W-1:0] dot_limit_reg;
    logic [mtd_pkg::LIMIT_W-1:0] dash_limit_reg;
    logic [mtd_pkg::LIMIT_W-1:0] letter_end_reg;

    logic                 tone_active_reg, tone_active_next;
    logic [TICK_BITS-1:0] tone_ticks_reg, tone_ticks_next;
    logic [4:0]           symbol_pattern_reg, symbol_pattern_next;
    logic [2:0]           symbol_count_reg, symbol_count_next;
    logic                 space_pending_reg, space_pending_next;

    logic                 accept;
    logic                 room;
    logic                 cfg_write;
    logic [TICK_BITS-1:0] ticks_inc;
    logic [CMP_W-1:0]     dur;
    logic                 tone_on;
    logic [6:0]           letter;
    mtd_pkg::push_t       push;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign s_ready   = room;
    assign accept    = s_valid && s_ready;

    // Configuration register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg  <= mtd_pkg::THRESHOLD_RST;
            dot_limit_reg  <= mtd_pkg::DOT_LIMIT_RST;
            dash_limit_reg <= mtd_pkg::DASH_LIMIT_RST;
            letter_end_reg <= mtd_pkg::LETTER_END_RST;
        end else if (cfg_write) begin
            case (paddr[3:2])
                mtd_pkg::REG_THRESHOLD:  threshold_reg  <= pwdata[mtd_pkg::THR_W-1:0];
                mtd_pkg::REG_DOT_LIMIT:  dot_limit_reg  <= pwdata[mtd_pkg::LIMIT_W-1:0];
                mtd_pkg::REG_DASH_LIMIT: dash_limit_reg <= pwdata[mtd_pkg::LIMIT_W-1:0];
                mtd_pkg::REG_LETTER_END: letter_end_reg <= pwdata[mtd_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (paddr[3:2])
            mtd_pkg::REG_THRESHOLD:  prdata = 32'(threshold_reg);
            mtd_pkg::REG_DOT_LIMIT:  prdata = 32'(dot_limit_reg);
            mtd_pkg::REG_DASH_LIMIT: prdata = 32'(dash_limit_reg);
            mtd_pkg::REG_LETTER_END: prdata = 32'(letter_end_reg);
            default:                 prdata = '0;
        endcase
    end

    // Saturating tick count, the tone test and the pending letter lookup.
    assign ticks_inc = (tone_ticks_reg != {TICK_BITS{1'b1}}) ?
                       tone_ticks_reg + TICK_BITS'(1) : tone_ticks_reg;
    assign dur       = CMP_W'(ticks_inc);
    assign tone_on   = (s_data.sample > threshold_reg);
    assign letter    = mtd_pkg::decode_letter(symbol_count_reg, symbol_pattern_reg);

    // State update and results for the accepted item.
    always_comb begin
        logic       is_dash;
        logic       add_sym;
        is_dash             = 1'b0;
        add_sym             = 1'b0;
        tone_active_next    = tone_active_reg;
        tone_ticks_next     = tone_ticks_reg;
        symbol_pattern_next = symbol_pattern_reg;
        symbol_count_next   = symbol_count_reg;
        space_pending_next  = space_pending_reg;
        push.n              = 2'd0;
        push.first          = '{kind: mtd_pkg::KIND_END, char_code: mtd_pkg::CH_NONE,
                                last: 1'b0};
        push.second         = '{kind: mtd_pkg::KIND_END, char_code: mtd_pkg::CH_NONE,
                                last: 1'b1};

        if (accept) begin
            if (s_data.mode == mtd_pkg::MODE_FLUSH) begin
                // Flush: pending letter if any, then message end.
                if (symbol_count_reg != 3'd0) begin
                    push.n     = 2'd2;
                    push.first = '{kind: mtd_pkg::KIND_CHAR, char_code: letter,
                                   last: 1'b0};
                end else begin
                    push.n     = 2'd1;
                    push.first = '{kind: mtd_pkg::KIND_END, char_code: mtd_pkg::CH_NONE,
                                   last: 1'b1};
                end
                symbol_pattern_next = '0;
                symbol_count_next   = '0;
                space_pending_next  = 1'b0;
            end else if (!tone_active_reg) begin
                // Idle: a sample above the threshold starts a tone.
                if (tone_on) begin
                    tone_active_next = 1'b1;
                    tone_ticks_next  = '0;
                end
            end else begin
                // Tone in progress: time it and classify it when it ends.
                tone_ticks_next = ticks_inc;
                if (!tone_on) begin
                    tone_active_next = 1'b0;
                    if (dur < CMP_W'(dot_limit_reg)) begin
                        add_sym    = 1'b1;
                        push.n     = 2'd1;
                        push.first = '{kind: mtd_pkg::KIND_DOT, char_code: mtd_pkg::CH_DOT,
                                       last: 1'b1};
                    end else if (dur < CMP_W'(dash_limit_reg)) begin
                        add_sym    = 1'b1;
                        is_dash    = 1'b1;
                        push.n     = 2'd1;
                        push.first = '{kind: mtd_pkg::KIND_DASH,
                                       char_code: mtd_pkg::CH_DASH, last: 1'b1};
                    end else if (dur >= CMP_W'(letter_end_reg)) begin
                        // Separator echo, then the letter or a pending word space, if there is one.
                        push.first = '{kind: mtd_pkg::KIND_SEP,
                                       char_code: mtd_pkg::CH_SPACE, last: 1'b1};
                        push.n     = 2'd1;
                        if (symbol_count_reg != 3'd0) begin
                            push.n           = 2'd2;
                            push.first.last  = 1'b0;
                            push.second      = '{kind: mtd_pkg::KIND_CHAR,
                                                 char_code: letter, last: 1'b1};
                            symbol_pattern_next = '0;
                            symbol_count_next   = '0;
                        end else if (space_pending_reg) begin
                            push.n           = 2'd2;
                            push.first.last  = 1'b0;
                            push.second      = '{kind: mtd_pkg::KIND_WORD,
                                                 char_code: mtd_pkg::CH_SPACE,
                                                 last: 1'b1};
                        end
                        space_pending_next = !space_pending_reg;
                    end
                end
            end
        end

        // Append a dot or dash to the letter; a sixth symbol marks it overlong.
        if (add_sym) begin
            space_pending_next = 1'b0;
            if (symbol_count_reg < mtd_pkg::COUNT_MAX) begin
                symbol_pattern_next = symbol_pattern_reg |
                                      (5'(is_dash) << symbol_count_reg);
                symbol_count_next   = symbol_count_reg + 3'd1;
            end else begin
                symbol_count_next = mtd_pkg::COUNT_OVER;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tone_active_reg    <= 1'b0;
            tone_ticks_reg     <= '0;
            symbol_pattern_reg <= '0;
            symbol_count_reg   <= '0;
            space_pending_reg  <= 1'b0;
        end else begin
            tone_active_reg    <= tone_active_next;
            tone_ticks_reg     <= tone_ticks_next;
            symbol_pattern_reg <= symbol_pattern_next;
            symbol_count_reg   <= symbol_count_next;
            space_pending_reg  <= space_pending_next;
        end
    end

    // Result queue between the decoder and the output channel.
    mtd_out_fifo u_out_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // A flush leaves no letter and no pending separator behind.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.mode == mtd_pkg::MODE_FLUSH) |=>
        (symbol_count_reg == 3'd0 && symbol_pattern_reg == 5'd0 && !space_pending_reg))
        else $error("flush did not clear the letter state");

    // The symbol count never goes past the overlong mark.
    assert property (@(posedge aclk) disable iff (!aresetn)
        symbol_count_reg <= mtd_pkg::COUNT_OVER)
        else $error("symbol count out of range");

    // A tick with no tone running never causes a result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.mode == mtd_pkg::MODE_TICK && !tone_active_reg) |->
        (push.n == 2'd0))
        else $error("result caused while no tone was running");

endmodule

>>> rtl/mtd_out_fifo.sv
module mtd_out_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  mtd_pkg::push_t  push,
    output logic            room,
    output logic            m_valid,
    input  logic            m_ready,
    output mtd_pkg::out_t   m_data
);

    localparam int PW = mtd_pkg::OUT_PTR_W;
    localparam int CW = mtd_pkg::OUT_CNT_W;

    mtd_pkg::out_t  mem_reg [mtd_pkg::OUT_DEPTH];
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           pop;

    // Output side reads the head entry.
    assign m_valid = (count_reg != '0);
    assign m_data  = mem_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;

    // Room for the two results an item may cause.
    assign room = (count_reg <= CW'(mtd_pkg::OUT_DEPTH - 2));

    // Pointer and fill level updates.
    always_comb begin
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        wr_ptr_next = wr_ptr_reg + PW'(push.n);
        count_next  = count_reg + CW'(push.n) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry writes; the second result goes one slot after the first.
    always_ff @(posedge aclk) begin
        if (push.n != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.n == 2'd2) begin
            mem_reg[wr_ptr_reg + PW'(1)] <= push.second;
        end
    end

    // The fill level never passes the depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(mtd_pkg::OUT_DEPTH))
        else $error("result queue overfilled");

    // Results are only pushed when there is room for them.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push.n != 2'd0) |-> room)
        else $error("push into result queue without room");

    // A pop with no push lowers the fill level by one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && push.n == 2'd0) |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("result queue level did not drop on pop");

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mtd_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned RANDOM_GOAL  = 60;

    typedef enum logic [1:0] {TONE_DOT, TONE_DASH, TONE_SEP, TONE_GAP} tone_class_e;

    // Dot and dash marks of the letters and digits, in the order of morse_chars.
    string morse_marks [36] = '{
        ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
        "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
        "..-", "...-", ".--", "-..-", "-.--", "--..", ".----", "..---", "...--", "....-",
        ".....", "-....", "--...", "---..", "----.", "-----"
    };
    string morse_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZ1234567890";

    logic          aclk;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    in_t           s_data  = '0;
    logic          m_valid;
    logic          m_ready = 1'b1;
    out_t          m_data;
    logic          psel    = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite  = 1'b0;
    logic [3:0]    paddr   = '0;
    logic [31:0]   pwdata  = '0;
    logic [31:0]   prdata;
    logic          pready;

    // Register copies and decoder state of the predictor.
    logic [THR_W-1:0]   cfg_threshold  = THRESHOLD_RST;
    logic [LIMIT_W-1:0] cfg_dot        = DOT_LIMIT_RST;
    logic [LIMIT_W-1:0] cfg_dash       = DASH_LIMIT_RST;
    logic [LIMIT_W-1:0] cfg_letter_end = LETTER_END_RST;
    logic               tone_on   = 1'b0;
    logic [15:0]        tone_cnt  = '0;
    logic [4:0]         sym_bits  = '0;
    logic [2:0]         sym_cnt   = '0;
    logic               space_due = 1'b0;

    out_t        expected_symbols [$];
    out_t        oldest_symbol;
    logic        idling_on      = 1'b1;
    int unsigned error_count    = 0;
    int unsigned items_accepted = 0;
    int unsigned filler_items   = 0;
    int unsigned results_seen   = 0;
    int unsigned settings_used  = 0;
    int unsigned cycle_count    = 0;

    morse_tone_decoder dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results still expected", $time,
                     expected_symbols.size());
            $display("FAIL morse_tone_decoder");
            $finish;
        end
    end

    // The result side stalls in random bursts while idling is enabled.
    initial begin
        forever begin
            @(posedge aclk);
            if (idling_on && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    // Every accepted result is compared with the oldest expected one.
    // Fields are printed as kind/char/last.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_symbols.size() == 0) begin
                $display("%0t: unexpected result, nothing expected, got %0d/%h/%b",
                         $time, m_data.kind, m_data.char_code, m_data.last);
                error_count++;
            end else begin
                oldest_symbol = expected_symbols.pop_front();
                if (m_data.kind !== oldest_symbol.kind ||
                    m_data.char_code !== oldest_symbol.char_code ||
                    m_data.last !== oldest_symbol.last) begin
                    $display("%0t: mismatch, expected %0d/%h/%b, got %0d/%h/%b",
                             $time, oldest_symbol.kind, oldest_symbol.char_code,
                             oldest_symbol.last, m_data.kind, m_data.char_code, m_data.last);
                    error_count++;
                end
            end
        end
    end

    // Looks up a letter code; anything empty, overlong or missing gives the unknown mark.
    function automatic logic [6:0] letter_for_code(input logic [2:0] cnt, input logic [4:0] bits);
        string      marks;
        logic       same;
        logic [6:0] ch;
        ch = CH_UNKNOWN;
        if (cnt != 0 && cnt <= COUNT_MAX) begin
            for (int i = 0; i < 36; i++) begin
                marks = morse_marks[i];
                if (marks.len() == cnt) begin
                    same = 1'b1;
                    for (int j = 0; j < marks.len(); j++) begin
                        if ((marks[j] == "-") != bits[j])
                            same = 1'b0;
                    end
                    if (same)
                        ch = 7'(morse_chars[i]);
                end
            end
        end
        return ch;
    endfunction

    task automatic append_symbol(input logic is_dash);
        space_due = 1'b0;
        if (sym_cnt < COUNT_MAX) begin
            if (is_dash)
                sym_bits[sym_cnt] = 1'b1;
            sym_cnt++;
        end else begin
            sym_cnt = COUNT_OVER;
        end
    endtask

    // Advances the decoder state by one item and queues the symbols it yields.
    task automatic predict_item(input in_t item);
        out_t res [2];
        int   n;
        n = 0;
        if (item.mode == MODE_FLUSH) begin
            if (sym_cnt != 0) begin
                res[n] = out_t'{KIND_CHAR, letter_for_code(sym_cnt, sym_bits), 1'b0};
                n++;
            end
            res[n] = out_t'{KIND_END, CH_NONE, 1'b0};
            n++;
            sym_bits  = '0;
            sym_cnt   = '0;
            space_due = 1'b0;
        end else if (!tone_on) begin
            if (item.sample > cfg_threshold) begin
                tone_on  = 1'b1;
                tone_cnt = '0;
            end
        end else begin
            if (tone_cnt != 16'hFFFF)
                tone_cnt++;
            if (item.sample <= cfg_threshold) begin
                tone_on = 1'b0;
                if (tone_cnt < cfg_dot) begin
                    res[n] = out_t'{KIND_DOT, CH_DOT, 1'b0};
                    n++;
                    append_symbol(1'b0);
                end else if (tone_cnt < cfg_dash) begin
                    res[n] = out_t'{KIND_DASH, CH_DASH, 1'b0};
                    n++;
                    append_symbol(1'b1);
                end else if (tone_cnt >= cfg_letter_end) begin
                    res[n] = out_t'{KIND_SEP, CH_SPACE, 1'b0};
                    n++;
                    if (sym_cnt != 0) begin
                        res[n] = out_t'{KIND_CHAR, letter_for_code(sym_cnt, sym_bits), 1'b0};
                        n++;
                        sym_bits = '0;
                        sym_cnt  = '0;
                    end
                    if (space_due) begin
                        if (n < 2) begin
                            res[n] = out_t'{KIND_WORD, CH_SPACE, 1'b0};
                            n++;
                        end
                        space_due = 1'b0;
                    end else begin
                        space_due = 1'b1;
                    end
                end
            end
        end
        if (n > 0)
            res[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            expected_symbols.push_back(res[i]);
        items_accepted++;
    endtask

    // Offers one item, waits for it to be taken, then predicts its symbols.
    task automatic send_item(input logic mode, input logic [11:0] sample);
        in_t item;
        item.mode   = mode;
        item.sample = sample;
        if (idling_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_item(item);
    endtask

    function automatic logic [11:0] high_sample();
        return 12'($urandom_range(int'(cfg_threshold) + 1, 4095));
    endfunction

    function automatic logic [11:0] low_sample();
        return 12'($urandom_range(0, int'(cfg_threshold)));
    endfunction

    // A tone of the given length: start tick, len-1 held ticks, then the falling tick.
    task automatic send_tone(input int unsigned len);
        send_item(MODE_TICK, high_sample());
        repeat (len - 1) send_item(MODE_TICK, high_sample());
        send_item(MODE_TICK, low_sample());
    endtask

    // Picks a tone length for a class under the current limits.
    function automatic int unsigned tone_length(input tone_class_e cls);
        int unsigned lo;
        int unsigned hi;
        case (cls)
            TONE_DOT: begin
                lo = 1;
                hi = (cfg_dot > 1) ? int'(cfg_dot) - 1 : 1;
            end
            TONE_DASH: begin
                lo = (cfg_dot > 1) ? int'(cfg_dot) : 1;
                hi = (cfg_dash > lo) ? int'(cfg_dash) - 1 : lo;
            end
            TONE_SEP: begin
                lo = (cfg_letter_end > 1) ? int'(cfg_letter_end) : 1;
                hi = lo + 3;
            end
            default: begin
                lo = (cfg_dash > 1) ? int'(cfg_dash) : 1;
                if (cfg_dot > lo)
                    lo = int'(cfg_dot);
                hi = (cfg_letter_end > lo) ? int'(cfg_letter_end) - 1 : lo;
            end
        endcase
        return $urandom_range(lo, hi);
    endfunction

    // Quiet ticks that the decoder ignores.
    task automatic pause_low();
        repeat ($urandom_range(0, 2)) begin
            send_item(MODE_TICK, low_sample());
            filler_items++;
        end
    endtask

    task automatic send_letter(input string marks);
        for (int i = 0; i < marks.len(); i++) begin
            send_tone(tone_length(marks[i] == "-" ? TONE_DASH : TONE_DOT));
            pause_low();
        end
    endtask

    // Lowers valid, waits for every expected symbol, then lets the pipeline settle.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_symbols.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_THRESHOLD:  cfg_threshold  = value[THR_W-1:0];
            REG_DOT_LIMIT:  cfg_dot        = value[LIMIT_W-1:0];
            REG_DASH_LIMIT: cfg_dash       = value[LIMIT_W-1:0];
            REG_LETTER_END: cfg_letter_end = value[LIMIT_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic check_register(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== value) begin
            $display("%0t: register %0d read mismatch, expected %h, actual %h",
                     $time, idx, value, prdata);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_limits(input logic [11:0] thr, input logic [15:0] dot,
                                input logic [15:0] dash, input logic [15:0] letter_end);
        write_register(REG_THRESHOLD, 32'(thr));
        write_register(REG_DOT_LIMIT, 32'(dot));
        write_register(REG_DASH_LIMIT, 32'(dash));
        write_register(REG_LETTER_END, 32'(letter_end));
        settings_used++;
    endtask

    // Defaults after reset, and one short dot decoded by a flush.
    task automatic test_reset_values();
        check_register(REG_THRESHOLD, 32'(THRESHOLD_RST));
        check_register(REG_DOT_LIMIT, 32'(DOT_LIMIT_RST));
        check_register(REG_DASH_LIMIT, 32'(DASH_LIMIT_RST));
        check_register(REG_LETTER_END, 32'(LETTER_END_RST));
        send_tone(1);
        send_item(MODE_FLUSH, 12'hFFF);
        wait_drained();
    endtask

    // Each symbol kind, word spaces, the dead band, threshold equality and flushes.
    task automatic test_symbols();
        write_limits(12'd2048, 16'd2, 16'd3, 16'd4);
        send_tone(2);
        send_tone(1);
        send_tone(4);
        send_tone(5);
        send_tone(3);
        // A sample equal to the threshold neither starts nor holds a tone.
        send_item(MODE_TICK, 12'd2048);
        send_item(MODE_TICK, 12'hFFF);
        send_item(MODE_TICK, 12'd2048);
        // A flush inside a tone leaves the tone timing alone.
        send_item(MODE_TICK, 12'hFFF);
        send_item(MODE_FLUSH, 12'h000);
        send_item(MODE_TICK, 12'd2049);
        send_item(MODE_TICK, 12'h000);
        send_item(MODE_FLUSH, 12'hABC);
        send_item(MODE_FLUSH, 12'h543);
        wait_drained();
    endtask

    // Codes missing from the table, a five-symbol digit and an overlong letter.
    task automatic test_odd_letters();
        send_letter("..--");
        send_tone(tone_length(TONE_SEP));
        send_letter("-----");
        send_tone(tone_length(TONE_SEP));
        send_letter("......");
        send_tone(tone_length(TONE_SEP));
        send_letter("-.-.-.-");
        send_item(MODE_FLUSH, 12'h000);
        wait_drained();
    endtask

    // Limits at both ends, crossed limits and a threshold that no sample exceeds.
    task automatic test_limit_extremes();
        write_limits(12'd0, 16'd0, 16'd0, 16'd0);
        check_register(REG_THRESHOLD, 32'd0);
        send_item(MODE_TICK, 12'd0);
        send_tone(1);
        send_tone(2);
        send_tone(1);
        wait_drained();
        write_limits(12'd4095, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        check_register(REG_DOT_LIMIT, 32'h0000_FFFF);
        check_register(REG_LETTER_END, 32'h0000_FFFF);
        send_item(MODE_TICK, 12'hFFF);
        send_item(MODE_TICK, 12'h000);
        send_item(MODE_TICK, 12'hFFF);
        wait_drained();
        write_limits(12'd100, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_tone(1);
        send_tone(7);
        send_item(MODE_FLUSH, 12'h000);
        wait_drained();
        // The dot test runs first even when its limit lies above the dash limit.
        write_limits(12'd1000, 16'd5, 16'd2, 16'd3);
        send_tone(4);
        send_tone(6);
        send_tone(5);
        send_tone(2);
        send_item(MODE_FLUSH, 12'h000);
        wait_drained();
    endtask

    // Mostly well-formed letters and words with random content, some noise.
    task automatic run_random_phase(input int unsigned goal);
        int unsigned start;
        int unsigned pick;
        string       marks;
        start = items_accepted - filler_items;
        while (items_accepted - filler_items - start < goal) begin
            pick = $urandom_range(0, 99);
            if (tone_on)
                send_item(MODE_TICK, low_sample());
            if (pick < 50) begin
                send_letter(morse_marks[$urandom_range(0, 35)]);
                send_tone(tone_length(TONE_SEP));
                if ($urandom_range(0, 9) < 3)
                    send_tone(tone_length(TONE_SEP));
            end else if (pick < 65) begin
                marks = "";
                repeat ($urandom_range(1, 7))
                    marks = {marks, ($urandom_range(0, 1) ? "-" : ".")};
                send_letter(marks);
                send_tone(tone_length(TONE_SEP));
            end else if (pick < 75) begin
                send_tone(tone_length(TONE_GAP));
            end else if (pick < 85) begin
                send_letter(morse_marks[$urandom_range(0, 35)]);
                send_item(MODE_FLUSH, 12'($urandom_range(0, 4095)));
            end else begin
                repeat ($urandom_range(1, 12))
                    send_item(($urandom_range(0, 7) == 0) ? MODE_FLUSH : MODE_TICK,
                              12'($urandom_range(0, 4095)));
            end
        end
    endtask

    task automatic write_random_limits();
        logic [15:0] dot;
        logic [15:0] dash;
        dot  = 16'($urandom_range(2, 6));
        dash = 16'(dot + $urandom_range(1, 5));
        write_limits(12'($urandom_range(0, 4094)), dot, dash,
                     16'(dash + $urandom_range(0, 5)));
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 12; phase++) begin
            idling_on = ($urandom_range(0, 3) != 0);
            write_random_limits();
            run_random_phase(RANDOM_GOAL);
            wait_drained();
        end
        idling_on = 1'b1;
    endtask

    // The closing stretch runs with no stalls on either side.
    task automatic test_full_rate();
        idling_on = 1'b0;
        for (int phase = 0; phase < 2; phase++) begin
            write_random_limits();
            run_random_phase(RANDOM_GOAL / 2);
            wait_drained();
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_values();
        test_symbols();
        test_odd_letters();
        test_limit_extremes();
        test_random_traffic();
        test_full_rate();
        wait_drained();
        repeat (20) @(posedge aclk);
        $display("Covered %0d items and %0d results over %0d register settings,",
                 items_accepted, results_seen, settings_used);
        $display("including crossed and extreme limits, odd letters and word spaces.");
        if (error_count == 0) begin
            $display("PASS morse_tone_decoder");
        end else begin
            $display("FAIL morse_tone_decoder");
        end
        $finish;
    end

endmodule
